[rtl/core/nft_pkg.sv]
`default_nettype none

package nft_pkg;

    // Widths of the request and response fields.
    localparam int REQ_W    = 3;
    localparam int FIDX_W   = 5;
    localparam int PID_W    = 10;
    localparam int PAGE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int CLS_W    = 3;
    // Index carried by the search token; wide enough for tables of up to 256 frames.
    localparam int TOK_IDX_W = 8;

    localparam logic [REQ_W-1:0] REQ_RESERVE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ASSIGN    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR_REF = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE_PROC = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TOUCH     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_FREE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EVICT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd3;

    localparam logic [2:0] CMD_NOP       = 3'd0;
    localparam logic [2:0] CMD_ASSIGN    = 3'd1;
    localparam logic [2:0] CMD_CLEAR_REF = 3'd2;
    localparam logic [2:0] CMD_FREE_PROC = 3'd3;
    localparam logic [2:0] CMD_TOUCH     = 3'd4;
    localparam logic [2:0] CMD_LOCK      = 3'd5;

    // Class value that is worse than any real class (2*R+M is at most 3).
    localparam logic [CLS_W-1:0] NO_CLASS = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [FIDX_W-1:0] frame_index;
        logic [PID_W-1:0]  proc_id;
        logic [PAGE_W-1:0] page_number;
        logic              holds_table;
        logic              is_write;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   chosen_frame;
        logic                victim_had_owner;
        logic [PID_W-1:0]    victim_owner;
        logic [PAGE_W-1:0]   victim_page;
        logic                victim_dirty;
    } t_rsp;

    typedef struct packed {
        logic [2:0] op;
        logic       holds_table;
        logic       is_write;
    } t_cmd;

    typedef struct packed {
        logic                 valid;
        logic                 have_free;
        logic [CLS_W-1:0]     cls;
        logic [TOK_IDX_W-1:0] idx;
        logic                 owned;
        logic [PID_W-1:0]     owner;
        logic [PAGE_W-1:0]    page;
        logic                 dirty;
    } t_token;

endpackage

`default_nettype wire

[rtl/core/nft_cell.sv]
`default_nettype none

module nft_cell
    import nft_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int PROC_BITS = 10,
    parameter int PAGE_BITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_sel,
    input  wire logic [PROC_BITS-1:0] i_pid,
    input  wire logic [PAGE_BITS-1:0] i_page,
    input  wire t_token               i_token,
    output t_token                    o_token
);

    logic                 r_free;
    logic                 r_tbl;
    logic                 r_own;
    logic                 r_ref;
    logic                 r_dirty;
    logic [PROC_BITS-1:0] r_owner;
    logic [PAGE_BITS-1:0] r_page;
    t_token               r_tok;
    t_token               n_tok;

    logic [31:0]      owner_ext;
    logic [31:0]      page_ext;
    logic [CLS_W-1:0] my_cls;

    assign owner_ext = 32'(r_owner);
    assign page_ext  = 32'(r_page);
    assign my_cls    = {1'b0, r_ref, r_dirty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= 1'b1;
            r_tbl   <= 1'b0;
            r_own   <= 1'b0;
            r_ref   <= 1'b0;
            r_dirty <= 1'b0;
        end else begin
            case (i_cmd.op)
                CMD_ASSIGN: begin
                    if (i_sel) begin
                        r_free  <= 1'b0;
                        r_tbl   <= i_cmd.holds_table;
                        r_own   <= 1'b1;
                        r_ref   <= 1'b1;
                        r_dirty <= 1'b0;
                    end
                end
                CMD_CLEAR_REF: begin
                    if (!r_free && !r_tbl) begin
                        r_ref <= 1'b0;
                    end
                end
                CMD_FREE_PROC: begin
                    if (!r_free && r_own && (r_owner == i_pid)) begin
                        r_free  <= 1'b1;
                        r_tbl   <= 1'b0;
                        r_own   <= 1'b0;
                        r_ref   <= 1'b0;
                        r_dirty <= 1'b0;
                    end
                end
                CMD_TOUCH: begin
                    if (i_sel && !r_free) begin
                        r_ref <= 1'b1;
                        if (i_cmd.is_write) begin
                            r_dirty <= 1'b1;
                        end
                    end
                end
                CMD_LOCK: begin
                    if (i_sel) begin
                        r_free  <= 1'b0;
                        r_tbl   <= 1'b0;
                        r_own   <= 1'b0;
                        r_ref   <= 1'b0;
                        r_dirty <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Owner and page are cleared whenever a frame is locked or released, so a
    // frame can only be reported with values that were written by some request.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_ASSIGN: begin
                if (i_sel) begin
                    r_owner <= i_pid;
                    r_page  <= i_page;
                end
            end
            CMD_FREE_PROC: begin
                if (!r_free && r_own && (r_owner == i_pid)) begin
                    r_owner <= '0;
                    r_page  <= '0;
                end
            end
            CMD_LOCK: begin
                if (i_sel) begin
                    r_owner <= '0;
                    r_page  <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // A free frame always wins; otherwise a data frame replaces the running
    // best only with a strictly lower class, so the lowest index keeps ties.
    always_comb begin
        n_tok = i_token;
        if (i_token.valid && !i_token.have_free) begin
            if (r_free) begin
                n_tok.have_free = 1'b1;
                n_tok.idx       = TOK_IDX_W'(IDX);
            end else if (!r_tbl && (my_cls < i_token.cls)) begin
                n_tok.cls   = my_cls;
                n_tok.idx   = TOK_IDX_W'(IDX);
                n_tok.owned = r_own;
                n_tok.owner = owner_ext[PID_W-1:0];
                n_tok.page  = page_ext[PAGE_W-1:0];
                n_tok.dirty = r_dirty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.have_free <= n_tok.have_free;
        r_tok.cls       <= n_tok.cls;
        r_tok.idx       <= n_tok.idx;
        r_tok.owned     <= n_tok.owned;
        r_tok.owner     <= n_tok.owner;
        r_tok.page      <= n_tok.page;
        r_tok.dirty     <= n_tok.dirty;
    end

    assign o_token = r_tok;

endmodule

`default_nettype wire

[rtl/core/nru_frame_table.sv]
// Frame table with not-recently-used replacement.
// Requests arrive on i_in_valid / o_in_ready / i_in_data, one response per
// request leaves on o_out_valid / i_out_ready / o_out_data.
// Each frame lives in one cell of a chain. Assign, clear-referenced, free-process
// and touch requests are broadcast to all cells and finish in the cycle they are
// accepted; the response is in the output register on the next cycle.
// A reserve request sends a search token down the chain, one cell per cycle,
// collecting the lowest free frame or the best NRU victim. When the token
// leaves the last cell, the chosen frame is locked and the response is parked;
// it moves to the output register once that register is free.
// One request is in work at a time; a new request is taken once the block is
// idle and the output register is empty or being emptied in that cycle. So a
// broadcast request can follow another every cycle, while the request after a
// reserve is taken only once its response has moved to the output register.
// If the receiver stalls, the response waits in the output register and
// further requests wait with it.
// After reset every frame is free and unowned with R and M clear, and the
// output register is empty.
`default_nettype none

module nru_frame_table
    import nft_pkg::*;
#(
    parameter int NUM_FRAMES = 32,
    parameter int PROC_BITS  = 10,
    parameter int PAGE_BITS  = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_scan_go;
    logic       r_out_valid;
    t_rsp       r_out;
    t_rsp       r_pend;

    logic       in_acc;
    logic       out_free;
    logic       scan_done;
    logic       do_lock;
    t_cmd       cmd;
    t_token     tok [NUM_FRAMES+1];
    t_token     tok_last;
    logic [NUM_FRAMES-1:0] sel;
    logic [NUM_FRAMES-1:0] tok_valids;
    logic [31:0] sel_idx;
    logic [31:0] pid_ext;
    logic [31:0] page_ext;
    logic [PROC_BITS-1:0] pid;
    logic [PAGE_BITS-1:0] page;
    t_rsp       done_rsp;
    t_rsp       scan_rsp;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pid_ext  = 32'(i_in_data.proc_id);
    assign page_ext = 32'(i_in_data.page_number);
    assign pid      = pid_ext[PROC_BITS-1:0];
    assign page     = page_ext[PAGE_BITS-1:0];

    always_comb begin
        tok[0]           = '0;
        tok[0].valid     = r_scan_go;
        tok[0].have_free = 1'b0;
        tok[0].cls       = NO_CLASS;
    end

    assign tok_last  = tok[NUM_FRAMES];
    assign scan_done = (r_state == ST_SCAN) && tok_last.valid;
    assign do_lock   = scan_done && (tok_last.have_free || (tok_last.cls != NO_CLASS));

    always_comb begin
        cmd             = '0;
        cmd.op          = CMD_NOP;
        cmd.holds_table = i_in_data.holds_table;
        cmd.is_write    = i_in_data.is_write;
        if (do_lock) begin
            cmd.op = CMD_LOCK;
        end else if (in_acc) begin
            case (i_in_data.req_type)
                REQ_ASSIGN:    cmd.op = CMD_ASSIGN;
                REQ_CLEAR_REF: cmd.op = CMD_CLEAR_REF;
                REQ_FREE_PROC: cmd.op = CMD_FREE_PROC;
                REQ_TOUCH:     cmd.op = CMD_TOUCH;
                default:       cmd.op = CMD_NOP;
            endcase
        end
    end

    assign sel_idx = do_lock ? 32'(tok_last.idx) : 32'(i_in_data.frame_index);

    for (genvar gi = 0; gi < NUM_FRAMES; gi++) begin : g_cell
        assign sel[gi]        = (sel_idx == 32'(gi));
        assign tok_valids[gi] = tok[gi+1].valid;

        nft_cell #(
            .IDX       (gi),
            .PROC_BITS (PROC_BITS),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_sel   (sel[gi]),
            .i_pid   (pid),
            .i_page  (page),
            .i_token (tok[gi]),
            .o_token (tok[gi+1])
        );
    end

    always_comb begin
        done_rsp        = '0;
        done_rsp.status = STATUS_DONE;
    end

    always_comb begin
        scan_rsp = '0;
        if (tok_last.have_free) begin
            scan_rsp.status       = STATUS_FREE;
            scan_rsp.chosen_frame = tok_last.idx[FIDX_W-1:0];
        end else if (tok_last.cls != NO_CLASS) begin
            scan_rsp.status           = STATUS_EVICT;
            scan_rsp.chosen_frame     = tok_last.idx[FIDX_W-1:0];
            scan_rsp.victim_had_owner = tok_last.owned;
            scan_rsp.victim_owner     = tok_last.owner;
            scan_rsp.victim_page      = tok_last.page;
            scan_rsp.victim_dirty     = tok_last.dirty;
        end else begin
            scan_rsp.status = STATUS_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.req_type == REQ_RESERVE)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_last.valid) begin
                    n_state = ST_PEND;
                end
            end
            ST_PEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_go   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scan_go <= in_acc && (i_in_data.req_type == REQ_RESERVE);
            if (in_acc && (i_in_data.req_type != REQ_RESERVE)) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == ST_PEND) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_done) begin
            r_pend <= scan_rsp;
        end
        if (in_acc && (i_in_data.req_type != REQ_RESERVE)) begin
            r_out <= done_rsp;
        end else if ((r_state == ST_PEND) && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_reserve_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.req_type == REQ_RESERVE) |=> (r_state == ST_SCAN) && r_scan_go)
        else $error("reserve request did not start a scan");

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({tok_valids, r_scan_go}))
        else $error("more than one search token in the chain");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_last.valid |-> (r_state == ST_SCAN))
        else $error("search token finished outside a scan");

    a_lock_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == CMD_LOCK) |-> $onehot(sel))
        else $error("lock command does not select exactly one frame");

    a_pend_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |=> (r_state == ST_PEND) && !r_scan_go)
        else $error("finished scan did not park its response");

endmodule

`default_nettype wire

[verif/nru_tb_pkg.sv]
package nru_tb_pkg;
    import nft_pkg::*;

    localparam int FRAME_COUNT = 32;

    class nru_frame_checker;
        bit                frame_free[FRAME_COUNT];
        bit                frame_table[FRAME_COUNT];
        bit                frame_owned[FRAME_COUNT];
        logic [PID_W-1:0]  frame_owner[FRAME_COUNT];
        logic [PAGE_W-1:0] frame_page[FRAME_COUNT];
        bit                frame_ref[FRAME_COUNT];
        bit                frame_dirty[FRAME_COUNT];
        t_rsp              expected_rsp[$];
        int                errors;
        int                last_chosen;

        function new();
            for (int f = 0; f < FRAME_COUNT; f++) begin
                release_frame(f);
            end
            errors = 0;
            last_chosen = 0;
        endfunction

        function void lock_frame(int f);
            frame_free[f]  = 1'b0;
            frame_table[f] = 1'b0;
            frame_owned[f] = 1'b0;
            frame_owner[f] = '0;
            frame_page[f]  = '0;
            frame_ref[f]   = 1'b0;
            frame_dirty[f] = 1'b0;
        endfunction

        function void release_frame(int f);
            lock_frame(f);
            frame_free[f] = 1'b1;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function t_rsp predict_response(t_req r);
            t_rsp             rsp;
            logic [CLS_W-1:0] best;
            logic [CLS_W-1:0] cls;
            int               victim;
            int               idx;
            rsp = '0;
            rsp.status = STATUS_DONE;
            best = NO_CLASS;
            victim = 0;
            idx = int'(r.frame_index);
            case (r.req_type)
                REQ_RESERVE: begin
                    for (int f = 0; f < FRAME_COUNT; f++) begin
                        if (frame_free[f]) begin
                            lock_frame(f);
                            rsp.status = STATUS_FREE;
                            rsp.chosen_frame = FIDX_W'(f);
                            last_chosen = f;
                            return rsp;
                        end
                    end
                    // No free frame: lowest class 2*R+M among data frames, lowest index wins.
                    for (int f = 0; f < FRAME_COUNT; f++) begin
                        if (!frame_table[f]) begin
                            cls = {1'b0, frame_ref[f], frame_dirty[f]};
                            if (cls < best) begin
                                best = cls;
                                victim = f;
                            end
                        end
                    end
                    if (best == NO_CLASS) begin
                        rsp.status = STATUS_NONE;
                    end else begin
                        rsp.status = STATUS_EVICT;
                        rsp.chosen_frame = FIDX_W'(victim);
                        rsp.victim_had_owner = frame_owned[victim];
                        rsp.victim_owner = frame_owner[victim];
                        rsp.victim_page = frame_page[victim];
                        rsp.victim_dirty = frame_dirty[victim];
                        lock_frame(victim);
                        last_chosen = victim;
                    end
                end
                REQ_ASSIGN: begin
                    if (idx < FRAME_COUNT) begin
                        frame_free[idx]  = 1'b0;
                        frame_table[idx] = r.holds_table;
                        frame_owned[idx] = 1'b1;
                        frame_owner[idx] = r.proc_id;
                        frame_page[idx]  = r.page_number;
                        frame_ref[idx]   = 1'b1;
                        frame_dirty[idx] = 1'b0;
                    end
                end
                REQ_CLEAR_REF: begin
                    for (int f = 0; f < FRAME_COUNT; f++) begin
                        if (!frame_free[f] && !frame_table[f]) frame_ref[f] = 1'b0;
                    end
                end
                REQ_FREE_PROC: begin
                    for (int f = 0; f < FRAME_COUNT; f++) begin
                        if (!frame_free[f] && frame_owned[f] && frame_owner[f] == r.proc_id)
                            release_frame(f);
                    end
                end
                REQ_TOUCH: begin
                    if (idx < FRAME_COUNT && !frame_free[idx]) begin
                        frame_ref[idx] = 1'b1;
                        if (r.is_write) frame_dirty[idx] = 1'b1;
                    end
                end
                default: ;
            endcase
            return rsp;
        endfunction

        function void note_request(t_req r);
            expected_rsp.push_back(predict_response(r));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: response with no request pending, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("chosen_frame", want.chosen_frame, got.chosen_frame);
            compare_field("victim_had_owner", want.victim_had_owner, got.victim_had_owner);
            compare_field("victim_owner", want.victim_owner, got.victim_owner);
            compare_field("victim_page", want.victim_page, got.victim_page);
            compare_field("victim_dirty", want.victim_dirty, got.victim_dirty);
        endfunction
    endclass

endpackage

[verif/tb.sv]
module tb;
    import nft_pkg::*;
    import nru_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    nru_frame_checker frames_sb;
    int               tx_idle_pct;
    int               rx_stall_pct;
    logic [PID_W-1:0] pid_pool[4] = '{10'h000, 10'h3FF, 10'h155, 10'h2AA};

    nru_frame_table #(
        .NUM_FRAMES(FRAME_COUNT),
        .PROC_BITS (PID_W),
        .PAGE_BITS (PAGE_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_req make_req(logic [REQ_W-1:0] kind, int frame,
                                      logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                                      logic tbl, logic wr);
        t_req r;
        r.req_type    = kind;
        r.frame_index = FIDX_W'(frame);
        r.proc_id     = pid;
        r.page_number = page;
        r.holds_table = tbl;
        r.is_write    = wr;
        return r;
    endfunction

    // Mostly reserve/assign/touch traffic on a small set of processes, so the table
    // fills up and evictions happen; a few requests carry unknown types.
    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.frame_index = FIDX_W'($urandom_range(0, FRAME_COUNT - 1));
        r.proc_id     = ($urandom_range(0, 4) == 0) ? PID_W'($urandom)
                                                    : pid_pool[$urandom_range(0, 3)];
        r.page_number = PAGE_W'($urandom);
        r.holds_table = ($urandom_range(0, 15) == 0);
        r.is_write    = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            r.req_type = REQ_RESERVE;
        end else if (pick < 60) begin
            r.req_type = REQ_ASSIGN;
            if ($urandom_range(0, 1)) r.frame_index = FIDX_W'(frames_sb.last_chosen);
        end else if (pick < 80) begin
            r.req_type = REQ_TOUCH;
        end else if (pick < 87) begin
            r.req_type = REQ_CLEAR_REF;
        end else if (pick < 95) begin
            r.req_type = REQ_FREE_PROC;
        end else begin
            r.req_type = REQ_TOUCH + REQ_W'($urandom_range(1, 3));
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        frames_sb.note_request(r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frames_sb.pending() > 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) frames_sb.check_response(o_out_data);
    end

    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                i_out_ready <= 1'b0;
                stall = gap_len() - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int tx_set[4];
        int rx_set[4];
        tx_set = '{0, 30, 60, 10};
        rx_set = '{0, 30, 10, 60};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        frames_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_stall_pct = 20;
        send_req(make_req(REQ_RESERVE, 0, '0, '0, 1'b0, 1'b0));
        send_req(make_req(REQ_ASSIGN, 0, '1, '1, 1'b0, 1'b1));
        send_req(make_req(REQ_TOUCH, 0, '0, '0, 1'b0, 1'b1));
        // A touch of a free frame must leave it free.
        send_req(make_req(REQ_TOUCH, 5, '0, '0, 1'b1, 1'b1));
        send_req(make_req(REQ_CLEAR_REF, 31, '1, '1, 1'b1, 1'b1));
        for (int k = 1; k <= 3; k++) begin
            send_req(make_req(REQ_TOUCH + REQ_W'(k), 31, '1, '1, 1'b1, 1'b1));
        end
        send_req(make_req(REQ_FREE_PROC, 0, '1, '0, 1'b0, 1'b0));

        // Fill the table with page-table frames, leaving frame 7 as the only data frame.
        for (int f = 0; f < FRAME_COUNT; f++) begin
            send_req(make_req(REQ_ASSIGN, f, pid_pool[2], PAGE_W'(f * 33), f != 7, 1'b0));
        end
        send_req(make_req(REQ_TOUCH, 7, '0, '0, 1'b0, 1'b1));
        // The second eviction hits the same frame, now locked and unowned.
        send_req(make_req(REQ_RESERVE, 0, '0, '0, 1'b0, 1'b0));
        send_req(make_req(REQ_RESERVE, 0, '0, '0, 1'b0, 1'b0));
        send_req(make_req(REQ_ASSIGN, 7, pid_pool[2], '1, 1'b1, 1'b0));
        send_req(make_req(REQ_RESERVE, 0, '0, '0, 1'b0, 1'b0));
        send_req(make_req(REQ_FREE_PROC, 0, pid_pool[2], '0, 1'b0, 1'b0));
        send_req(make_req(REQ_RESERVE, 0, '0, '0, 1'b0, 1'b0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = tx_set[ph];
            rx_stall_pct = rx_set[ph];
            for (int n = 0; n < 125; n++) begin
                send_req(random_req());
            end
            drain();
        end

        repeat (FRAME_COUNT + 8) @(posedge i_clk);
        if (frames_sb.errors == 0 && frames_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
